>>> rtl/ccr_pkg.sv
`default_nettype none
package ccr_pkg;
  localparam int unsigned PosW = 20;
  localparam int unsigned RegW = 12;
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegWidth = 8'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 8'd1;
  localparam logic [RegW-1:0] WidthReset = 12'd800;
  localparam logic [RegW-1:0] HeightReset = 12'd600;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic            last;
  } ball_t;

  // request/response between sequencer and the shared divide/sqrt unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [41:0] num;
    logic [41:0] den;
  } du_req_t;

  typedef struct packed {
    logic        done;
    logic [41:0] res;
  } du_rsp_t;
endpackage
`default_nettype wire

>>> rtl/ccr_if.sv
`default_nettype none
interface ccr_ball_if;
  logic          valid;
  logic          ready;
  ccr_pkg::ball_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [11:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> rtl/ccr_ram.sv
`default_nettype none
module ccr_ram #(
  parameter int unsigned Width = 20,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/ccr_divsqrt.sv
`default_nettype none
module ccr_divsqrt (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  ccr_pkg::du_req_t req_i,
  output ccr_pkg::du_rsp_t rsp_o
);
  import ccr_pkg::*;
  // restoring divide or digit-by-digit sqrt, one bit per cycle
  logic        busy_q, busy_d, sq_q, sq_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [41:0] rem_q, rem_d, num_q, num_d, den_q, den_d, res_q, res_d, bit_q, bit_d;
  logic        done_q, done_d;
  logic [42:0] trial;
  logic [41:0] sq_sum;

  assign sq_sum = res_q + bit_q;
  assign trial = {rem_q[41:0], num_q[41]} - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q; sq_d = sq_q; cnt_d = cnt_q; rem_d = rem_q; num_d = num_q;
    den_d = den_q; res_d = res_q; bit_d = bit_q; done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1; sq_d = req_i.is_sqrt; num_d = req_i.num; den_d = req_i.den;
      rem_d = '0; res_d = '0; cnt_d = 6'd42;
      bit_d = 42'd1 << 40;
      if (req_i.is_sqrt) begin
        rem_d = req_i.num; cnt_d = 6'd21;
      end
    end else if (busy_q) begin
      if (sq_q) begin
        if (rem_q >= sq_sum) begin
          rem_d = rem_q - sq_sum; res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else begin
        num_d = num_q << 1;
        if (!trial[42]) begin
          rem_d = trial[41:0]; res_d = {res_q[40:0], 1'b1};
        end else begin
          rem_d = {rem_q[40:0], num_q[41]}; res_d = {res_q[40:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d; rem_q <= rem_d; num_q <= num_d; den_q <= den_d;
    res_q <= res_d; bit_q <= bit_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res = res_q;
endmodule
`default_nettype wire

>>> rtl/circle_collision_resolver_top.sv
`default_nettype none
// Loads up to MaxBalls positions, one transaction per cycle; the last ball starts the pair pass.
// Per ordered pair with j unequal to i: reads both balls and forms the squared distance; on
// contact, runs a sqrt and two divides in the shared bit-serial divide/sqrt unit.
// Output: one ball at a time, each held in S_OUT until the sink is ready.
// The block takes no item while solving or emitting.
// Reset (async, active low) clears the ball count, the sequencer and sets the window to 800x600.
module circle_collision_resolver_top #(
  parameter int unsigned MaxBalls = 64,
  parameter int unsigned BallDiameterPx = 20,
  parameter int unsigned EdgeMarginPx = 10
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  ccr_ball_if.sink   in_i,
  ccr_ball_if.source out_o,
  ccr_cfg_if.sink    cfg_i
);
  import ccr_pkg::*;
  localparam int unsigned AW = $clog2(MaxBalls);
  localparam int unsigned CW = AW + 1;
  localparam logic signed [23:0] Dia = 24'(BallDiameterPx * 256);
  localparam logic [41:0] Dia2 = 42'(BallDiameterPx * BallDiameterPx * 65536);
  localparam logic signed [23:0] Lo = 24'(EdgeMarginPx * 256);

  typedef enum logic [3:0] {
    S_LOAD, S_RDI, S_RDJ, S_WAIT, S_CALC, S_SQRT, S_DIVX, S_DIVY, S_WRI, S_WRJ, S_NEXT,
    S_ORD, S_OWAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [CW-1:0] cnt_q, i_q, j_q;
  logic [RegW-1:0] ww_q, wh_q;
  logic signed [23:0] xi_q, yi_q, xj_q, yj_q, dx_q, dy_q, px_q, py_q;
  logic [41:0] d2_q, dist_q, delta_q;
  logic [41:0] d2_c;
  du_req_t req;
  du_rsp_t rsp;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [PosW-1:0] wx, wy, rx, ry;
  logic [1:0] phase_q;
  logic [41:0] adx, ady, dsub;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [20:0] sq_a;

  ccr_ram #(.Width(PosW), .Depth(MaxBalls)) u_rx (.clk_i, .we_i(we), .waddr_i(waddr),
    .wdata_i(wx), .raddr_i(raddr), .rdata_o(rx));
  ccr_ram #(.Width(PosW), .Depth(MaxBalls)) u_ry (.clk_i, .we_i(we), .waddr_i(waddr),
    .wdata_i(wy), .raddr_i(raddr), .rdata_o(ry));
  ccr_divsqrt u_du (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  function automatic logic signed [23:0] clampf(logic signed [23:0] p, logic [RegW-1:0] s);
    logic signed [23:0] hi, r;
    hi = ($signed({12'd0, s}) - 24'(EdgeMarginPx)) <<< 8;
    r = p;
    if (r > hi) r = hi;
    if (r < Lo) r = Lo;
    return r;
  endfunction

  function automatic logic [41:0] absv(logic signed [23:0] v);
    return 42'(v < 0 ? -v : v);
  endfunction

  logic signed [23:0] nxi, nyi, nxj, nyj;
  assign nxi = clampf(xi_q + px_q, ww_q);
  assign nyi = clampf(yi_q + py_q, wh_q);
  assign nxj = clampf(xj_q - px_q, ww_q);
  assign nyj = clampf(yj_q - py_q, wh_q);

  assign adx = absv(dx_q);
  assign ady = absv(dy_q);
  assign sq_a = adx[20:0];
  assign d2_c = 42'(sq_a) * 42'(sq_a);

  // push numerator: |d| and overlap are both below the diameter, so 16 bits suffice
  assign dsub = 42'(Dia) - rsp.res;
  assign mul_a = (state_q == S_SQRT) ? adx[15:0] : ady[15:0];
  assign mul_b = (state_q == S_SQRT) ? dsub[15:0] : delta_q[15:0];
  assign mul_p = 32'(mul_a) * 32'(mul_b);

  logic load_acc;
  assign in_i.ready = (state_q == S_LOAD);
  assign load_acc = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    we = 1'b0; waddr = cnt_q[AW-1:0]; wx = in_i.data.x; wy = in_i.data.y;
    raddr = i_q[AW-1:0];
    req = '0;
    unique case (state_q)
      S_LOAD: we = load_acc && (cnt_q < CW'(MaxBalls));
      S_RDJ: raddr = j_q[AW-1:0];
      S_WRI: begin we = 1'b1; waddr = i_q[AW-1:0]; wx = nxi[PosW-1:0]; wy = nyi[PosW-1:0]; end
      S_WRJ: begin we = 1'b1; waddr = j_q[AW-1:0]; wx = nxj[PosW-1:0]; wy = nyj[PosW-1:0]; end
      S_CALC: begin
        req.start = (phase_q == 2'd2) && (d2_q != 0) && (d2_q < Dia2);
        req.is_sqrt = 1'b1; req.num = d2_q;
      end
      S_SQRT: begin
        req.start = rsp.done; req.num = 42'(mul_p) + rsp.res;
        req.den = rsp.res << 1;
      end
      S_DIVX: begin
        req.start = rsp.done; req.num = 42'(mul_p) + dist_q;
        req.den = dist_q << 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; cnt_q <= '0; i_q <= '0; j_q <= '0; phase_q <= '0;
      ww_q <= WidthReset; wh_q <= HeightReset;
      out_o.valid <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == RegWidth) ww_q <= cfg_i.wdata;
        else if (cfg_i.index == RegHeight) wh_q <= cfg_i.wdata;
      end
      unique case (state_q)
        S_LOAD: if (load_acc) begin
          if (cnt_q < CW'(MaxBalls)) cnt_q <= cnt_q + 1'b1;
          if (in_i.data.last) begin
            i_q <= '0; j_q <= '0; state_q <= S_NEXT;
          end
        end
        S_RDI: state_q <= S_RDJ;
        S_RDJ: begin xi_q <= $signed({4'd0, rx}); yi_q <= $signed({4'd0, ry}); state_q <= S_WAIT; end
        S_WAIT: begin
          xj_q <= $signed({4'd0, rx}); yj_q <= $signed({4'd0, ry});
          dx_q <= xi_q - $signed({4'd0, rx}); dy_q <= yi_q - $signed({4'd0, ry});
          phase_q <= '0; state_q <= S_CALC;
        end
        S_CALC: begin
          // d2 accumulated through one multiplier (dx squared, then dy squared added), then checked for contact
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd0) begin d2_q <= d2_c; dx_q <= dy_q; dy_q <= dx_q; end
          else if (phase_q == 2'd1) begin d2_q <= d2_q + d2_c; dx_q <= dy_q; dy_q <= dx_q; end
          else if ((d2_q != 0) && (d2_q < Dia2)) state_q <= S_SQRT;
          else begin j_q <= j_q + 1'b1; state_q <= S_NEXT; end
        end
        S_SQRT: if (rsp.done) begin
          dist_q <= rsp.res; delta_q <= 42'(Dia) - rsp.res; state_q <= S_DIVX;
        end
        S_DIVX: if (rsp.done) begin
          px_q <= dx_q < 0 ? -24'(rsp.res) : 24'(rsp.res); state_q <= S_DIVY;
        end
        S_DIVY: if (rsp.done) begin
          py_q <= dy_q < 0 ? -24'(rsp.res) : 24'(rsp.res); state_q <= S_WRI;
        end
        S_WRI: state_q <= S_WRJ;
        S_WRJ: begin j_q <= j_q + 1'b1; state_q <= S_NEXT; end
        S_NEXT: begin
          if (i_q >= cnt_q) begin i_q <= '0; state_q <= S_ORD; end
          else if (j_q >= cnt_q) begin i_q <= i_q + 1'b1; j_q <= '0; end
          else if (j_q == i_q) j_q <= j_q + 1'b1;
          else state_q <= S_RDI;
        end
        S_ORD: begin state_q <= S_OWAIT; end
        S_OWAIT: begin
          out_o.valid <= 1'b1;
          out_o.data.x <= rx; out_o.data.y <= ry;
          out_o.data.last <= (i_q + 1'b1 == cnt_q);
          state_q <= S_OUT;
        end
        S_OUT: if (out_o.ready) begin
          out_o.valid <= 1'b0;
          if (i_q + 1'b1 >= cnt_q) begin cnt_q <= '0; state_q <= S_LOAD; end
          else begin i_q <= i_q + 1'b1; state_q <= S_ORD; end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire
